### hw/rtl/pidaw_pkg.sv
package pidaw_pkg;

  localparam int unsigned CfgAddrW = 6;

  typedef enum logic [2:0] {
    REG_KP    = 3'd0,
    REG_KI    = 3'd1,
    REG_KD    = 3'd2,
    REG_OLIM  = 3'd3,
    REG_ILIM  = 3'd4,
    REG_KT    = 3'd5,
    REG_DBAND = 3'd6,
    REG_MODE  = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_BACK  = 2'd1,
    MODE_COND  = 2'd2,
    MODE_NONE  = 2'd3
  } aw_mode_t;

  localparam logic OP_DERIVE = 1'b0;
  localparam logic OP_GIVEN  = 1'b1;

  // Request to the shared serial multiplier.
  typedef struct packed {
    logic start;
    logic sh32;
  } mul_ctl_t;

endpackage

### hw/rtl/pidaw_if.sv
interface pidaw_in_if #(parameter int DW = 32);
  logic valid;
  logic ready;
  logic opcode;
  logic signed [DW-1:0] error_sample;
  logic signed [DW-1:0] error_rate;
  logic [31:0] step_time;
  modport source (output valid, opcode, error_sample, error_rate, step_time, input ready);
  modport sink (input valid, opcode, error_sample, error_rate, step_time, output ready);
endinterface

interface pidaw_out_if #(parameter int DW = 32);
  logic valid;
  logic ready;
  logic signed [DW-1:0] command;
  logic signed [DW-1:0] integral_value;
  logic signed [DW-1:0] derivative_value;
  logic saturated;
  modport source (output valid, command, integral_value, derivative_value, saturated,
                  input ready);
  modport sink (input valid, command, integral_value, derivative_value, saturated,
                output ready);
endinterface

### hw/rtl/pidaw_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle. Magnitude product
// is shifted right (by FRAC_BITS or 32), truncated toward zero, and saturated.
module pidaw_mul #(
  parameter int AW = 64,
  parameter int BW = 32,
  parameter int FB = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pidaw_pkg::mul_ctl_t  ctl,
  input  logic signed [AW-1:0] a,
  input  logic        [BW:0]   b,
  input  logic                 b_neg,
  input  logic [AW-1:0]        lim,
  output logic                 done,
  output logic signed [AW-1:0] result
);
  localparam int PW = AW + BW + 1;
  localparam int CW = $clog2(BW + 2);

  logic [PW-1:0] acc_r, acc_nxt;
  logic [AW-1:0] ma_r;
  logic [BW:0]   mb_r;
  logic          neg_r, sh32_r, busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [PW-1:0] shifted;
  logic [AW-1:0] mag_a;

  assign mag_a = a[AW-1] ? AW'(-a) : AW'(a);
  assign acc_nxt = acc_r + (mb_r[0] ? (PW'(ma_r) << cnt_r) : '0);
  assign shifted = sh32_r ? (acc_r >> 32) : (acc_r >> FB);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        acc_r  <= '0;
        ma_r   <= mag_a;
        mb_r   <= b;
        neg_r  <= a[AW-1] ^ b_neg;
        sh32_r <= ctl.sh32;
        cnt_r  <= '0;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        mb_r  <= mb_r >> 1;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(BW)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  logic [PW-1:0] sat;
  assign sat = (shifted > PW'(lim)) ? PW'(lim) : shifted;
  assign result = neg_r ? -$signed(AW'(sat)) : $signed(AW'(sat));
  assign done = done_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("multiplier busy at done");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("done held for two cycles");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !busy_r) else $error("multiplier started while busy");
endmodule

### hw/rtl/pidaw_div.sv
// Restoring divider, one quotient bit per cycle: q = (n << 32) / d.
module pidaw_div #(
  parameter int DW = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DW:0]          num,
  input  logic [31:0]          den,
  output logic                 done,
  output logic [DW+32:0]       quot
);
  localparam int QW = DW + 33;
  localparam int CW = $clog2(QW + 1);
  logic [QW-1:0] q_r;
  logic [32:0]   rem_r;
  logic [31:0]   d_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [32:0]   trial;

  assign trial = {rem_r[31:0], q_r[QW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        q_r    <= {num, 32'd0};
        rem_r  <= '0;
        d_r    <= den;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (trial >= {1'b0, d_r}) begin
          rem_r <= trial - {1'b0, d_r};
          q_r   <= {q_r[QW-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          q_r   <= {q_r[QW-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
  assign quot = q_r;
  assign done = done_r;
endmodule

### hw/rtl/pid_controller_antiwindup.sv
// Channel  | Direction | Contents
// in       | sink      | opcode, error_sample, error_rate, step_time
// out      | source    | command, integral_value, derivative_value, saturated
// cfg      | APB slave | eight registers, 64-bit data, byte address 8*i
// With a given rate a transaction runs four products on the shared bit-serial
// multiplier in this order: proportional, derivative, then the sum, then integral and
// step scaling, followed by the integral update and the output. Back-calculation adds
// a fifth product, and a derived rate first adds a division on the serial divider.
// A zero step skips the arithmetic and repeats the last command. Reset is synchronous.
// The input is not taken while an item is in progress or a result waits; a stalled
// result holds.
module pid_controller_antiwindup #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk,
  input  logic rst_n,
  pidaw_in_if.sink    in_ch,
  pidaw_out_if.source out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [pidaw_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [63:0]                   cfg_pwdata,
  output logic [63:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  localparam int DW = DATA_WIDTH;
  localparam int AW = 64;
  localparam logic [AW-1:0] TermLim = AW'(1) << 60;
  localparam logic [AW-1:0] IncLim  = AW'(1) << 61;
  localparam logic signed [AW-1:0] SMax = AW'((AW'(1) << (DW - 1)) - 1);
  localparam logic signed [AW-1:0] SMin = -SMax - 1;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_MP, S_MD, S_SUM, S_MI, S_MT, S_MY, S_INT, S_OUT
  } state_t;

  logic signed [DW-1:0] kp_r, ki_r, kd_r, umin_r, umax_r, imin_r, imax_r;
  logic [DW-1:0] kt_r;
  logic [DW-2:0] dband_r;
  pidaw_pkg::aw_mode_t mode_r;
  logic signed [DW-1:0] prev_r, integ_r, lastcmd_r;

  state_t state_r;
  logic signed [DW-1:0] e_r, rate_r;
  logic [31:0] dt_r;
  logic signed [AW-1:0] p_r, unsat_r, cmd_r, ie_r, y_r;
  logic started_r;
  logic out_valid_r;
  logic signed [DW-1:0] o_cmd_r, o_int_r, o_der_r;
  logic o_sat_r;

  pidaw_pkg::mul_ctl_t mctl;
  logic signed [AW-1:0] ma;
  logic [DW:0] mb;
  logic mbneg, mdone;
  logic [AW-1:0] mlim;
  logic signed [AW-1:0] mres;

  logic dstart, ddone;
  logic [DW:0] dnum;
  logic [DW+32:0] dq;

  pidaw_mul #(.AW(AW), .BW(DW), .FB(FRAC_BITS)) u_mul (
    .clk, .rst_n, .ctl(mctl), .a(ma), .b(mb), .b_neg(mbneg), .lim(mlim),
    .done(mdone), .result(mres));
  pidaw_div #(.DW(DW)) u_div (
    .clk, .rst_n, .start(dstart), .num(dnum), .den(dt_r), .done(ddone), .quot(dq));

  // Configuration port.
  logic cfg_wr;
  pidaw_pkg::reg_idx_t widx;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign widx = pidaw_pkg::reg_idx_t'(cfg_paddr[5:3]);

  always_comb begin
    cfg_prdata = '0;
    case (widx)
      pidaw_pkg::REG_KP:    cfg_prdata = 64'(unsigned'(kp_r));
      pidaw_pkg::REG_KI:    cfg_prdata = 64'(unsigned'(ki_r));
      pidaw_pkg::REG_KD:    cfg_prdata = 64'(unsigned'(kd_r));
      pidaw_pkg::REG_OLIM:  cfg_prdata = {32'(unsigned'(umax_r)), 32'(unsigned'(umin_r))};
      pidaw_pkg::REG_ILIM:  cfg_prdata = {32'(unsigned'(imax_r)), 32'(unsigned'(imin_r))};
      pidaw_pkg::REG_KT:    cfg_prdata = 64'(kt_r);
      pidaw_pkg::REG_DBAND: cfg_prdata = 64'(dband_r);
      pidaw_pkg::REG_MODE:  cfg_prdata = 64'(mode_r);
      default:              cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r <= '0; ki_r <= '0; kd_r <= '0; kt_r <= '0; dband_r <= '0;
      mode_r <= pidaw_pkg::MODE_PLAIN;
      umax_r <= SMax[DW-1:0]; umin_r <= SMin[DW-1:0];
      imax_r <= SMax[DW-1:0]; imin_r <= SMin[DW-1:0];
    end else if (cfg_wr) begin
      case (widx)
        pidaw_pkg::REG_KP:    kp_r <= cfg_pwdata[DW-1:0];
        pidaw_pkg::REG_KI:    ki_r <= cfg_pwdata[DW-1:0];
        pidaw_pkg::REG_KD:    kd_r <= cfg_pwdata[DW-1:0];
        pidaw_pkg::REG_OLIM: begin
          umin_r <= cfg_pwdata[DW-1:0];
          umax_r <= cfg_pwdata[DW+31:32];
        end
        pidaw_pkg::REG_ILIM: begin
          imin_r <= cfg_pwdata[DW-1:0];
          imax_r <= cfg_pwdata[DW+31:32];
        end
        pidaw_pkg::REG_KT:    kt_r <= cfg_pwdata[DW-1:0];
        pidaw_pkg::REG_DBAND: dband_r <= cfg_pwdata[DW-2:0];
        pidaw_pkg::REG_MODE:  mode_r <= pidaw_pkg::aw_mode_t'(cfg_pwdata[1:0]);
        default: ;
      endcase
    end
  end

  // Derived rate: signed difference, magnitude division, saturate.
  logic signed [DW:0] diff;
  logic [DW:0] mdiff;
  logic diff_neg;
  logic [DW+32:0] rlim, qsat;
  assign diff = {e_r[DW-1], e_r} - {prev_r[DW-1], prev_r};
  assign diff_neg = diff[DW];
  assign mdiff = diff_neg ? -diff : diff;
  assign dnum = mdiff;
  assign rlim = diff_neg ? ((DW+33)'(1) << (DW - 1)) : (((DW+33)'(1) << (DW - 1)) - 1);
  assign qsat = (dq > rlim) ? rlim : dq;

  // Shared helpers.
  logic signed [AW-1:0] e_x, clamp_cmd, integ_sum, integ_clamp;
  logic [DW-1:0] mag_e;
  logic in_band, same_sign, do_int;
  assign e_x = AW'(e_r);
  assign mag_e = e_r[DW-1] ? DW'(-e_r) : DW'(e_r);
  assign in_band = mag_e <= DW'(dband_r);
  assign same_sign = (e_r > 0 && unsat_r > 0) || (e_r < 0 && unsat_r < 0);

  always_comb begin
    clamp_cmd = unsat_r;
    if (clamp_cmd > AW'(umax_r)) clamp_cmd = AW'(umax_r);
    if (clamp_cmd < AW'(umin_r)) clamp_cmd = AW'(umin_r);
  end

  always_comb begin
    do_int = 1'b0;
    if (!in_band) begin
      case (mode_r)
        pidaw_pkg::MODE_PLAIN: do_int = 1'b1;
        pidaw_pkg::MODE_BACK:  do_int = (ki_r != 0);
        pidaw_pkg::MODE_COND:  do_int = !(cmd_r != unsat_r && same_sign);
        default:               do_int = 1'b0;
      endcase
    end
  end

  assign integ_sum = AW'(integ_r) + (do_int ? mres : AW'(0));
  always_comb begin
    integ_clamp = integ_sum;
    if (integ_clamp > AW'(imax_r)) integ_clamp = AW'(imax_r);
    if (integ_clamp < AW'(imin_r)) integ_clamp = AW'(imin_r);
  end

  // Multiplier operand selection per state.
  always_comb begin
    ma = e_x; mb = '0; mbneg = 1'b0; mlim = TermLim;
    mctl.sh32 = 1'b0;
    mctl.start = !started_r &&
        (state_r == S_MP || state_r == S_MD || state_r == S_MI ||
         state_r == S_MT || state_r == S_MY);
    case (state_r)
      S_MP: begin ma = AW'(kp_r); mb = e_r[DW-1] ? -{1'b1, e_r} : {1'b0, e_r};
                  mbneg = e_r[DW-1]; end
      S_MD: begin ma = AW'(kd_r); mb = rate_r[DW-1] ? -{1'b1, rate_r} : {1'b0, rate_r};
                  mbneg = rate_r[DW-1]; end
      S_MI: begin ma = AW'(ki_r); mb = e_r[DW-1] ? -{1'b1, e_r} : {1'b0, e_r};
                  mbneg = e_r[DW-1]; end
      S_MT: begin ma = cmd_r - unsat_r; mb = {1'b0, kt_r}; end
      S_MY: begin ma = (mode_r == pidaw_pkg::MODE_BACK) ? y_r : ie_r;
                  mb = (DW+1)'(dt_r); mlim = IncLim; mctl.sh32 = 1'b1; end
      default: ;
    endcase
  end
  assign dstart = !started_r && state_r == S_DIV;

  assign in_ch.ready = (state_r == S_IDLE) && !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; started_r <= 1'b0; out_valid_r <= 1'b0;
      prev_r <= '0; integ_r <= '0; lastcmd_r <= '0;
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_ch.valid && !out_valid_r) begin
          e_r <= in_ch.error_sample; rate_r <= in_ch.error_rate;
          dt_r <= in_ch.step_time; started_r <= 1'b0;
          if (in_ch.step_time == 32'd0) begin
            o_cmd_r <= lastcmd_r; o_int_r <= integ_r; o_der_r <= '0; o_sat_r <= 1'b0;
            state_r <= S_OUT;
          end else if (in_ch.opcode == pidaw_pkg::OP_DERIVE) state_r <= S_DIV;
          else state_r <= S_MP;
        end
        S_DIV: begin
          if (ddone) begin
            rate_r <= diff_neg ? -DW'(qsat) : DW'(qsat);
            prev_r <= e_r; started_r <= 1'b0; state_r <= S_MP;
          end else started_r <= 1'b1;
        end
        S_MP: begin
          if (mdone) begin p_r <= mres; started_r <= 1'b0; state_r <= S_MD; end
          else started_r <= 1'b1;
        end
        S_MD: begin
          if (mdone) begin
            unsat_r <= p_r + AW'(integ_r) + mres; started_r <= 1'b0; state_r <= S_SUM;
          end else started_r <= 1'b1;
        end
        S_SUM: begin
          cmd_r <= clamp_cmd; state_r <= S_MI;
        end
        S_MI: begin
          if (mdone) begin
            ie_r <= mres; started_r <= 1'b0;
            state_r <= (mode_r == pidaw_pkg::MODE_BACK) ? S_MT : S_MY;
          end else started_r <= 1'b1;
        end
        S_MT: begin
          if (mdone) begin y_r <= ie_r + mres; started_r <= 1'b0; state_r <= S_MY; end
          else started_r <= 1'b1;
        end
        S_MY: begin
          if (mdone) begin started_r <= 1'b0; state_r <= S_INT; end
          else started_r <= 1'b1;
        end
        S_INT: begin
          integ_r <= integ_clamp[DW-1:0]; lastcmd_r <= cmd_r[DW-1:0];
          o_cmd_r <= cmd_r[DW-1:0]; o_int_r <= integ_clamp[DW-1:0];
          o_der_r <= rate_r; o_sat_r <= (cmd_r != unsat_r);
          state_r <= S_OUT;
        end
        S_OUT: begin out_valid_r <= 1'b1; state_r <= S_IDLE; end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.command = o_cmd_r;
  assign out_ch.integral_value = o_int_r;
  assign out_ch.derivative_value = o_der_r;
  assign out_ch.saturated = o_sat_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(o_cmd_r)))
    else $error("result dropped");
  a_zero_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && dt_r == 32'd0) |-> (o_sat_r == 1'b0))
    else $error("zero step flagged saturated");
endmodule
